/* design/rsh_pkg.sv */
// rsh_pkg: shared constants, basis index codes and coefficient table for the
// real spherical-harmonic basis evaluator
// no dependencies
package rsh_pkg;

	// fixed-point formats
	localparam int DIR_W         = 16;
	localparam int DEG_W         = 3;
	localparam int ORD_W         = 4;
	localparam int DIR_FRAC_BITS = 14;
	localparam int OUT_FRAC_BITS = 16;
	localparam int COEF_FRAC     = 24;
	localparam int OUT_W         = 20;

	// stream widths
	localparam int IN_FIELDS_W  = 3 * DIR_W + DEG_W + ORD_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W  = ((OUT_W + 7) / 8) * 8;

	// internal datapath widths
	localparam int SQ_W     = 18;
	localparam int CW       = 22;
	localparam int A_W      = 18;
	localparam int B_W      = 20;
	localparam int P_W      = 22;
	localparam int POLY_W   = 25;
	localparam int COEF_W   = 27;
	localparam int RES_W    = 30;
	localparam int OUT_SHIFT = DIR_FRAC_BITS + COEF_FRAC - OUT_FRAC_BITS;

	// basis index l*l + l + m
	typedef enum logic [4:0] {
		SH_00  = 5'd0,
		SH_1N1 = 5'd1,  SH_10  = 5'd2,  SH_1P1 = 5'd3,
		SH_2N2 = 5'd4,  SH_2N1 = 5'd5,  SH_20  = 5'd6,  SH_2P1 = 5'd7,  SH_2P2 = 5'd8,
		SH_3N3 = 5'd9,  SH_3N2 = 5'd10, SH_3N1 = 5'd11, SH_30  = 5'd12,
		SH_3P1 = 5'd13, SH_3P2 = 5'd14, SH_3P3 = 5'd15,
		SH_4N4 = 5'd16, SH_4N3 = 5'd17, SH_4N2 = 5'd18, SH_4N1 = 5'd19, SH_40 = 5'd20,
		SH_4P1 = 5'd21, SH_4P2 = 5'd22, SH_4P3 = 5'd23, SH_4P4 = 5'd24
	} basis_t;

	// coefficients in Q24, rounded from six-digit decimals
	localparam longint Q_SCALE = 64'sd1 <<< COEF_FRAC;
	localparam longint Q_0282095 = (64'sd282095  * Q_SCALE + 64'sd500000) / 64'sd1000000;
	localparam longint Q_0488603 = (64'sd488603  * Q_SCALE + 64'sd500000) / 64'sd1000000;
	localparam longint Q_1092548 = (64'sd1092548 * Q_SCALE + 64'sd500000) / 64'sd1000000;
	localparam longint Q_0315392 = (64'sd315392  * Q_SCALE + 64'sd500000) / 64'sd1000000;
	localparam longint Q_0546274 = (64'sd546274  * Q_SCALE + 64'sd500000) / 64'sd1000000;
	localparam longint Q_0590044 = (64'sd590044  * Q_SCALE + 64'sd500000) / 64'sd1000000;
	localparam longint Q_2890611 = (64'sd2890611 * Q_SCALE + 64'sd500000) / 64'sd1000000;
	localparam longint Q_0457046 = (64'sd457046  * Q_SCALE + 64'sd500000) / 64'sd1000000;
	localparam longint Q_0373176 = (64'sd373176  * Q_SCALE + 64'sd500000) / 64'sd1000000;
	localparam longint Q_1445306 = (64'sd1445306 * Q_SCALE + 64'sd500000) / 64'sd1000000;
	localparam longint Q_2503343 = (64'sd2503343 * Q_SCALE + 64'sd500000) / 64'sd1000000;
	localparam longint Q_1770131 = (64'sd1770131 * Q_SCALE + 64'sd500000) / 64'sd1000000;
	localparam longint Q_0946175 = (64'sd946175  * Q_SCALE + 64'sd500000) / 64'sd1000000;
	localparam longint Q_0669047 = (64'sd669047  * Q_SCALE + 64'sd500000) / 64'sd1000000;
	localparam longint Q_0105786 = (64'sd105786  * Q_SCALE + 64'sd500000) / 64'sd1000000;
	localparam longint Q_0473087 = (64'sd473087  * Q_SCALE + 64'sd500000) / 64'sd1000000;
	localparam longint Q_0625836 = (64'sd625836  * Q_SCALE + 64'sd500000) / 64'sd1000000;

	function automatic logic signed [COEF_W-1:0] coef_q24(input basis_t b);
		logic signed [COEF_W-1:0] c;
		case (b)
			SH_00:  c = COEF_W'(Q_0282095);
			SH_1N1: c = COEF_W'(Q_0488603);
			SH_10:  c = COEF_W'(Q_0488603);
			SH_1P1: c = COEF_W'(Q_0488603);
			SH_2N2: c = COEF_W'(Q_1092548);
			SH_2N1: c = COEF_W'(Q_1092548);
			SH_20:  c = COEF_W'(Q_0315392);
			SH_2P1: c = COEF_W'(Q_1092548);
			SH_2P2: c = COEF_W'(Q_0546274);
			SH_3N3: c = COEF_W'(Q_0590044);
			SH_3N2: c = COEF_W'(Q_2890611);
			SH_3N1: c = COEF_W'(Q_0457046);
			SH_30:  c = COEF_W'(Q_0373176);
			SH_3P1: c = COEF_W'(Q_0457046);
			SH_3P2: c = COEF_W'(Q_1445306);
			SH_3P3: c = COEF_W'(Q_0590044);
			SH_4N4: c = COEF_W'(Q_2503343);
			SH_4N3: c = COEF_W'(Q_1770131);
			SH_4N2: c = COEF_W'(Q_0946175);
			SH_4N1: c = COEF_W'(Q_0669047);
			SH_40:  c = COEF_W'(Q_0105786);
			SH_4P1: c = COEF_W'(Q_0669047);
			SH_4P2: c = COEF_W'(Q_0473087);
			SH_4P3: c = COEF_W'(Q_1770131);
			SH_4P4: c = COEF_W'(Q_0625836);
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

/* design/rsh_mulrnd.sv */
// rsh_mulrnd: registered signed multiply with a rounding right shift,
// rounding half away from zero
// depends on nothing outside this file
module rsh_mulrnd #(
	parameter int A_W   = 16,
	parameter int B_W   = 16,
	parameter int P_W   = 18,
	parameter int SHIFT = 14
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [A_W-1:0] a,
	input  logic signed [B_W-1:0] b,
	output logic signed [P_W-1:0] p
);

	localparam int FULL_W = A_W + B_W;
	localparam int SUM_W  = FULL_W + 1;
	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (SHIFT - 1);

	logic signed [FULL_W-1:0] full;
	logic signed [SUM_W-1:0]  biased;
	logic signed [SUM_W-1:0]  shifted;
	logic signed [P_W-1:0]    prod_q;

	assign full    = a * b;
	// negative values round toward minus infinity after subtracting one
	assign biased  = $signed({full[FULL_W-1], full}) + HALF
		- $signed({{(SUM_W-1){1'b0}}, full[FULL_W-1]});
	assign shifted = biased >>> SHIFT;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= shifted[P_W-1:0];
		end
	end

	assign p = prod_q;

endmodule

/* design/real_sh_basis_eval.sv */
// real_sh_basis_eval: top level of the real spherical-harmonic basis evaluator
// depends on rsh_pkg and rsh_mulrnd
//
// Evaluates the real spherical-harmonic basis Y(l,m) for degrees 0 to 4 at a
// direction given in signed Q1.14 and returns the value in signed Q3.16,
// saturated to 20 bits. One transfer is taken every cycle unless back pressure
// has filled the pipeline. The seven register stages are input capture, the
// pairwise component products, polynomial operand selection, the second
// product, the polynomial sum, the coefficient product and output saturation.
// Each stage holds its item only while the stage after it is full and stalled,
// so back pressure on the result side fills bubbles before the input side is
// held. A degree above 4 or an order outside -degree..degree returns zero with
// index_valid low. Every product is rounded half away from zero.
module real_sh_basis_eval import rsh_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // dir_x, dir_y, dir_z, degree, order, pad
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // sh_value, pad
	output logic                   m_axis_tuser   // index_valid
);

	localparam logic signed [CW-1:0]    ONE_C   = CW'(2 ** DIR_FRAC_BITS);
	localparam logic signed [POLY_W-1:0] K35    = POLY_W'(35);
	localparam logic signed [RES_W-1:0] SAT_MAX = RES_W'(2 ** (OUT_W - 1) - 1);
	localparam logic signed [RES_W-1:0] SAT_MIN = -(RES_W'(2 ** (OUT_W - 1)));

	// stage valids and load enables
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic load1, load2, load3, load4, load5, load6, load7;

	assign load7 = !valid_s7 || m_axis_tready;
	assign load6 = !valid_s6 || load7;
	assign load5 = !valid_s5 || load6;
	assign load4 = !valid_s4 || load5;
	assign load3 = !valid_s3 || load4;
	assign load2 = !valid_s2 || load3;
	assign load1 = !valid_s1 || load2;

	assign s_axis_tready = load1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (load1) valid_s1 <= s_axis_tvalid;
			if (load2) valid_s2 <= valid_s1;
			if (load3) valid_s3 <= valid_s2;
			if (load4) valid_s4 <= valid_s3;
			if (load5) valid_s5 <= valid_s4;
			if (load6) valid_s6 <= valid_s5;
			if (load7) valid_s7 <= valid_s6;
		end
	end

	// stage 1: input capture
	logic signed [DIR_W-1:0] x_s1, y_s1, z_s1;
	logic [DEG_W-1:0]        degree_s1;
	logic signed [ORD_W-1:0] order_s1;

	always_ff @(posedge clk) begin
		if (load1) begin
			x_s1      <= s_axis_tdata[DIR_W-1:0];
			y_s1      <= s_axis_tdata[2*DIR_W-1:DIR_W];
			z_s1      <= s_axis_tdata[3*DIR_W-1:2*DIR_W];
			degree_s1 <= s_axis_tdata[3*DIR_W+DEG_W-1:3*DIR_W];
			order_s1  <= s_axis_tdata[IN_FIELDS_W-1:3*DIR_W+DEG_W];
		end
	end

	// stage 2: basis index and pairwise products
	logic [ORD_W-1:0] abs_order;
	logic [4:0]       band_base;
	logic [4:0]       idx_raw;
	logic             idx_ok;
	basis_t           idx_sel;

	always_comb begin
		abs_order = order_s1[ORD_W-1] ? ORD_W'(-order_s1) : order_s1;
		band_base = 5'(degree_s1) * 5'(degree_s1) + 5'(degree_s1);
		idx_raw   = band_base + 5'(order_s1);
		idx_ok    = (degree_s1 <= DEG_W'(4)) && (abs_order <= ORD_W'(degree_s1));
		idx_sel   = idx_ok ? basis_t'(idx_raw) : SH_00;
	end

	logic signed [DIR_W-1:0] x_s2, y_s2, z_s2;
	basis_t                  idx_s2;
	logic                    ok_s2;
	logic signed [SQ_W-1:0]  x2_s2, y2_s2, z2_s2, xy_s2, yz_s2, xz_s2;

	always_ff @(posedge clk) begin
		if (load2) begin
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			z_s2   <= z_s1;
			idx_s2 <= idx_sel;
			ok_s2  <= idx_ok;
		end
	end

	rsh_mulrnd #(.A_W(DIR_W), .B_W(DIR_W), .P_W(SQ_W), .SHIFT(DIR_FRAC_BITS)) u_x2 (
		.clk(clk), .en(load2), .a(x_s1), .b(x_s1), .p(x2_s2));
	rsh_mulrnd #(.A_W(DIR_W), .B_W(DIR_W), .P_W(SQ_W), .SHIFT(DIR_FRAC_BITS)) u_y2 (
		.clk(clk), .en(load2), .a(y_s1), .b(y_s1), .p(y2_s2));
	rsh_mulrnd #(.A_W(DIR_W), .B_W(DIR_W), .P_W(SQ_W), .SHIFT(DIR_FRAC_BITS)) u_z2 (
		.clk(clk), .en(load2), .a(z_s1), .b(z_s1), .p(z2_s2));
	rsh_mulrnd #(.A_W(DIR_W), .B_W(DIR_W), .P_W(SQ_W), .SHIFT(DIR_FRAC_BITS)) u_xy (
		.clk(clk), .en(load2), .a(x_s1), .b(y_s1), .p(xy_s2));
	rsh_mulrnd #(.A_W(DIR_W), .B_W(DIR_W), .P_W(SQ_W), .SHIFT(DIR_FRAC_BITS)) u_yz (
		.clk(clk), .en(load2), .a(y_s1), .b(z_s1), .p(yz_s2));
	rsh_mulrnd #(.A_W(DIR_W), .B_W(DIR_W), .P_W(SQ_W), .SHIFT(DIR_FRAC_BITS)) u_xz (
		.clk(clk), .en(load2), .a(x_s1), .b(z_s1), .p(xz_s2));

	// stage 3: operand selection per basis function
	logic signed [CW-1:0]  xw, yw, zw, x2w, y2w, z2w, xyw, yzw, xzw;
	logic signed [CW-1:0]  dxy, a3, b3, c4, t20, t30, t7a, t7b, c40;
	logic signed [A_W-1:0] a1, a2;
	logic signed [B_W-1:0] b1, b2;
	logic signed [CW-1:0]  cadd;
	logic                  m35;

	always_comb begin
		xw  = CW'(x_s2);
		yw  = CW'(y_s2);
		zw  = CW'(z_s2);
		x2w = CW'(x2_s2);
		y2w = CW'(y2_s2);
		z2w = CW'(z2_s2);
		xyw = CW'(xy_s2);
		yzw = CW'(yz_s2);
		xzw = CW'(xz_s2);
		dxy = x2w - y2w;
		a3  = CW'(3) * x2w - y2w;
		b3  = x2w - CW'(3) * y2w;
		c4  = CW'(4) * z2w - x2w - y2w;
		t20 = CW'(2) * z2w - x2w - y2w;
		t30 = CW'(2) * z2w - CW'(3) * x2w - CW'(3) * y2w;
		t7a = CW'(7) * z2w - ONE_C;
		t7b = CW'(7) * z2w - CW'(3) * ONE_C;
		c40 = CW'(3) * ONE_C - CW'(30) * z2w;
	end

	always_comb begin
		a1   = '0;
		b1   = '0;
		a2   = '0;
		b2   = '0;
		cadd = '0;
		m35  = 1'b0;
		case (idx_s2)
			SH_00:  cadd = ONE_C;
			SH_1N1: cadd = -yw;
			SH_10:  cadd = zw;
			SH_1P1: cadd = -xw;
			SH_2N2: cadd = xyw;
			SH_2N1: cadd = -yzw;
			SH_20:  cadd = t20;
			SH_2P1: cadd = -xzw;
			SH_2P2: cadd = dxy;
			SH_3N3: begin a1 = A_W'(-yw);  b1 = a3[B_W-1:0];  end
			SH_3N2: begin a1 = A_W'(xyw);  b1 = zw[B_W-1:0];  end
			SH_3N1: begin a1 = A_W'(-yw);  b1 = c4[B_W-1:0];  end
			SH_30:  begin a1 = A_W'(zw);   b1 = t30[B_W-1:0]; end
			SH_3P1: begin a1 = A_W'(-xw);  b1 = c4[B_W-1:0];  end
			SH_3P2: begin a1 = A_W'(zw);   b1 = dxy[B_W-1:0]; end
			SH_3P3: begin a1 = A_W'(-xw);  b1 = b3[B_W-1:0];  end
			SH_4N4: begin a1 = A_W'(xyw);  b1 = dxy[B_W-1:0]; end
			SH_4N3: begin a1 = A_W'(-yzw); b1 = a3[B_W-1:0];  end
			SH_4N2: begin a1 = A_W'(xyw);  b1 = t7a[B_W-1:0]; end
			SH_4N1: begin a1 = A_W'(-yzw); b1 = t7b[B_W-1:0]; end
			SH_40: begin
				a1   = A_W'(z2w);
				b1   = z2w[B_W-1:0];
				m35  = 1'b1;
				cadd = c40;
			end
			SH_4P1: begin a1 = A_W'(-xzw); b1 = t7b[B_W-1:0]; end
			SH_4P2: begin a1 = A_W'(dxy);  b1 = t7a[B_W-1:0]; end
			SH_4P3: begin a1 = A_W'(-xzw); b1 = b3[B_W-1:0];  end
			SH_4P4: begin
				a1 = A_W'(x2w);
				b1 = b3[B_W-1:0];
				a2 = A_W'(y2w);
				b2 = a3[B_W-1:0];
			end
			default: cadd = '0;
		endcase
	end

	logic signed [A_W-1:0] a1_s3, a2_s3;
	logic signed [B_W-1:0] b1_s3, b2_s3;
	logic signed [CW-1:0]  cadd_s3;
	logic                  m35_s3;
	basis_t                idx_s3;
	logic                  ok_s3;

	always_ff @(posedge clk) begin
		if (load3) begin
			a1_s3   <= a1;
			b1_s3   <= b1;
			a2_s3   <= a2;
			b2_s3   <= b2;
			cadd_s3 <= cadd;
			m35_s3  <= m35;
			idx_s3  <= idx_s2;
			ok_s3   <= ok_s2;
		end
	end

	// stage 4: second products
	logic signed [P_W-1:0] p1_s4, p2_s4;
	logic signed [CW-1:0]  cadd_s4;
	logic                  m35_s4;
	basis_t                idx_s4;
	logic                  ok_s4;

	rsh_mulrnd #(.A_W(A_W), .B_W(B_W), .P_W(P_W), .SHIFT(DIR_FRAC_BITS)) u_p1 (
		.clk(clk), .en(load4), .a(a1_s3), .b(b1_s3), .p(p1_s4));
	rsh_mulrnd #(.A_W(A_W), .B_W(B_W), .P_W(P_W), .SHIFT(DIR_FRAC_BITS)) u_p2 (
		.clk(clk), .en(load4), .a(a2_s3), .b(b2_s3), .p(p2_s4));

	always_ff @(posedge clk) begin
		if (load4) begin
			cadd_s4 <= cadd_s3;
			m35_s4  <= m35_s3;
			idx_s4  <= idx_s3;
			ok_s4   <= ok_s3;
		end
	end

	// stage 5: polynomial sum and coefficient lookup
	logic signed [POLY_W-1:0] p1w, poly;
	logic signed [POLY_W-1:0] poly_s5;
	logic signed [COEF_W-1:0] coef_s5;
	logic                     ok_s5;

	always_comb begin
		p1w  = POLY_W'(p1_s4);
		poly = (m35_s4 ? K35 * p1w : p1w) - POLY_W'(p2_s4) + POLY_W'(cadd_s4);
	end

	always_ff @(posedge clk) begin
		if (load5) begin
			poly_s5 <= poly;
			coef_s5 <= ok_s4 ? coef_q24(idx_s4) : '0;
			ok_s5   <= ok_s4;
		end
	end

	// stage 6: coefficient product to the output format
	logic signed [RES_W-1:0] res_s6;
	logic                    ok_s6;

	rsh_mulrnd #(.A_W(POLY_W), .B_W(COEF_W), .P_W(RES_W), .SHIFT(OUT_SHIFT)) u_coef (
		.clk(clk), .en(load6), .a(poly_s5), .b(coef_s5), .p(res_s6));

	always_ff @(posedge clk) begin
		if (load6) begin
			ok_s6 <= ok_s5;
		end
	end

	// stage 7: saturation
	logic signed [OUT_W-1:0] value_s7;
	logic                    ok_s7;

	always_ff @(posedge clk) begin
		if (load7) begin
			if (res_s6 > SAT_MAX) begin
				value_s7 <= SAT_MAX[OUT_W-1:0];
			end else if (res_s6 < SAT_MIN) begin
				value_s7 <= SAT_MIN[OUT_W-1:0];
			end else begin
				value_s7 <= res_s6[OUT_W-1:0];
			end
			ok_s7 <= ok_s6;
		end
	end

	assign m_axis_tvalid = valid_s7;
	assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}}, value_s7};
	assign m_axis_tuser  = ok_s7;

`ifndef SYNTH
	// unsupported index leaves the output at zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[OUT_W-1:0] == '0)
		else $error("nonzero value for an unsupported index");

	// input is held only when the result side is full and stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input held without output back pressure");

	// a zero coefficient must give a zero product
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 && !ok_s6 |-> res_s6 == '0)
		else $error("coefficient product nonzero for an unsupported index");

	// a stalled operand stage keeps its item
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !load4 |=> valid_s3 && $stable(a1_s3) && $stable(b1_s3))
		else $error("operand stage lost or changed a stalled item");
`endif

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking testbench for real_sh_basis_eval
// depends on rsh_pkg and the real_sh_basis_eval rtl; drives directions and basis
// indexes over the input stream and checks each basis value against its own predictor
`timescale 1ns / 100ps

module tb_top import rsh_pkg::*; ();

	typedef struct {
		logic signed [DIR_W-1:0] x;
		logic signed [DIR_W-1:0] y;
		logic signed [DIR_W-1:0] z;
		logic        [DEG_W-1:0] deg;
		logic signed [ORD_W-1:0] ord;
	} dir_item_t;

	typedef struct {
		logic signed [OUT_W-1:0] value;
		logic                    ok;
	} basis_res_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // dir_x, dir_y, dir_z, degree, order, pad
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;        // sh_value, pad
	logic                   m_axis_tuser;        // index_valid

	basis_res_t pending_basis[$];
	int src_idle_pct;
	int sink_stall_pct;
	int sink_hold_left;
	int items_sent;
	int values_checked;
	int bad_index_seen;
	int saturated_seen;
	int mismatches;

	real_sh_basis_eval dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	function automatic longint rnd_shr(longint v, int s);
		longint half;
		half = 64'sd1 <<< (s - 1);
		if (v >= 0)
			return (v + half) >>> s;
		return -((-v + half) >>> s);
	endfunction

	function automatic longint qmul(longint a, longint b);
		return rnd_shr(a * b, DIR_FRAC_BITS);
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint basis_coef(basis_t b);
		longint micro;
		case (b)
			SH_00:                  micro = 282095;
			SH_1N1, SH_10, SH_1P1:  micro = 488603;
			SH_2N2, SH_2N1, SH_2P1: micro = 1092548;
			SH_20:                  micro = 315392;
			SH_2P2:                 micro = 546274;
			SH_3N3, SH_3P3:         micro = 590044;
			SH_3N2:                 micro = 2890611;
			SH_3N1, SH_3P1:         micro = 457046;
			SH_30:                  micro = 373176;
			SH_3P2:                 micro = 1445306;
			SH_4N4:                 micro = 2503343;
			SH_4N3, SH_4P3:         micro = 1770131;
			SH_4N2:                 micro = 946175;
			SH_4N1, SH_4P1:         micro = 669047;
			SH_40:                  micro = 105786;
			SH_4P2:                 micro = 473087;
			SH_4P4:                 micro = 625836;
			default:                micro = 0;
		endcase
		return (micro * (64'sd1 <<< COEF_FRAC) + 64'sd500000) / 64'sd1000000;
	endfunction

	function automatic basis_res_t eval_basis(dir_item_t it);
		longint x, y, z, l, m, am, one;
		longint x2, y2, z2, xy, yz, xz, dxy, a3, b3, c4, p, v;
		basis_t b;
		basis_res_t r;
		x = longint'(it.x);
		y = longint'(it.y);
		z = longint'(it.z);
		l = longint'(it.deg);
		m = longint'(it.ord);
		am = m < 0 ? -m : m;
		if (l > 4 || am > l) begin
			r.value = '0;
			r.ok = 1'b0;
			return r;
		end
		one = 64'sd1 <<< DIR_FRAC_BITS;
		x2 = qmul(x, x);
		y2 = qmul(y, y);
		z2 = qmul(z, z);
		xy = qmul(x, y);
		yz = qmul(y, z);
		xz = qmul(x, z);
		dxy = x2 - y2;
		a3 = 3 * x2 - y2;
		b3 = x2 - 3 * y2;
		c4 = 4 * z2 - x2 - y2;
		b = basis_t'(l * l + l + m);
		case (b)
			SH_00:  p = one;
			SH_1N1: p = -y;
			SH_10:  p = z;
			SH_1P1: p = -x;
			SH_2N2: p = xy;
			SH_2N1: p = -yz;
			SH_20:  p = 2 * z2 - x2 - y2;
			SH_2P1: p = -xz;
			SH_2P2: p = dxy;
			SH_3N3: p = -qmul(y, a3);
			SH_3N2: p = qmul(xy, z);
			SH_3N1: p = -qmul(y, c4);
			SH_30:  p = qmul(z, 2 * z2 - 3 * x2 - 3 * y2);
			SH_3P1: p = -qmul(x, c4);
			SH_3P2: p = qmul(z, dxy);
			SH_3P3: p = -qmul(x, b3);
			SH_4N4: p = qmul(xy, dxy);
			SH_4N3: p = -qmul(yz, a3);
			SH_4N2: p = qmul(xy, 7 * z2 - one);
			SH_4N1: p = -qmul(yz, 7 * z2 - 3 * one);
			SH_40:  p = 35 * qmul(z2, z2) - 30 * z2 + 3 * one;
			SH_4P1: p = -qmul(xz, 7 * z2 - 3 * one);
			SH_4P2: p = qmul(dxy, 7 * z2 - one);
			SH_4P3: p = -qmul(xz, b3);
			SH_4P4: p = qmul(x2, b3) - qmul(y2, a3);
			default: p = 0;
		endcase
		p = clip(p, -(64'sd1 <<< 36), 64'sd1 <<< 36);
		v = rnd_shr(p * basis_coef(b), DIR_FRAC_BITS + COEF_FRAC - OUT_FRAC_BITS);
		v = clip(v, -(64'sd1 <<< (OUT_W - 1)), (64'sd1 <<< (OUT_W - 1)) - 1);
		r.value = v[OUT_W-1:0];
		r.ok = 1'b1;
		return r;
	endfunction

	task automatic send_dir(dir_item_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_TDATA_W'({it.ord, it.deg, it.z, it.y, it.x});
		do
			@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready));
		pending_basis.insert(pending_basis.size(), eval_basis(it));
		items_sent++;
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (pending_basis.size() > 0)
			@(posedge clk);
	endtask

	function automatic dir_item_t make_item(int x, int y, int z, int deg, int ord);
		dir_item_t it;
		it.x = DIR_W'(x);
		it.y = DIR_W'(y);
		it.z = DIR_W'(z);
		it.deg = DEG_W'(deg);
		it.ord = ORD_W'(ord);
		return it;
	endfunction

	// mostly a unit direction with a valid index, raw direction or index fields otherwise
	function automatic dir_item_t draw_item();
		dir_item_t it;
		real rx, ry, rz, norm;
		int kind;
		kind = $urandom_range(99);
		it.x = DIR_W'($urandom);
		it.y = DIR_W'($urandom);
		it.z = DIR_W'($urandom);
		it.deg = DEG_W'($urandom_range(4));
		it.ord = ORD_W'(int'($urandom_range(2 * it.deg)) - int'(it.deg));
		if (kind < 70) begin
			norm = 0.0;
			while (norm < 0.01) begin
				rx = (real'($urandom_range(20000)) - 10000.0) / 10000.0;
				ry = (real'($urandom_range(20000)) - 10000.0) / 10000.0;
				rz = (real'($urandom_range(20000)) - 10000.0) / 10000.0;
				norm = $sqrt(rx * rx + ry * ry + rz * rz);
			end
			it.x = DIR_W'(int'(rx / norm * 16384.0));
			it.y = DIR_W'(int'(ry / norm * 16384.0));
			it.z = DIR_W'(int'(rz / norm * 16384.0));
		end else if (kind >= 85) begin
			it.deg = DEG_W'($urandom);
			it.ord = ORD_W'($urandom);
		end
		return it;
	endfunction

	always @(posedge clk) begin
		if (sink_hold_left > 0) begin
			m_axis_tready <= 1'b0;
			sink_hold_left = sink_hold_left - 1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		basis_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_basis.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected transfer value=%0d valid=%0b", $time,
						$signed(m_axis_tdata[OUT_W-1:0]), m_axis_tuser);
			end else begin
				want = pending_basis.pop_front();
				values_checked++;
				if (!want.ok)
					bad_index_seen++;
				if (want.value == 20'sh7FFFF || want.value == 20'sh80000)
					saturated_seen++;
				if (m_axis_tdata[OUT_W-1:0] !== want.value || m_axis_tuser !== want.ok) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch value exp %0d got %0d, valid exp %0b got %0b",
							$time, want.value, $signed(m_axis_tdata[OUT_W-1:0]),
							want.ok, m_axis_tuser);
				end
			end
		end
	end

	// every basis index once, over axis, diagonal and extreme directions
	task automatic test_all_indexes;
		int dirs[8][3];
		int l, m;
		dirs = '{'{16384, 0, 0}, '{0, -16384, 0}, '{0, 0, 16384}, '{9459, 9459, 9459},
			'{32767, 32767, 32767}, '{-32768, -32768, -32768}, '{0, 0, 0},
			'{-32768, 32767, -16384}};
		for (l = 0; l <= 4; l++)
			for (m = -l; m <= l; m++)
				send_dir(make_item(dirs[(l * l + l + m) % 8][0], dirs[(l * l + l + m) % 8][1],
					dirs[(l * l + l + m) % 8][2], l, m));
		drain();
	endtask

	// degree above four and order beyond the band
	task automatic test_bad_index;
		int pairs[10][2];
		int i;
		pairs = '{'{5, 0}, '{7, -8}, '{6, 7}, '{0, 1}, '{0, -1},
			'{1, 2}, '{2, -3}, '{3, 4}, '{4, -5}, '{4, 5}};
		for (i = 0; i < 10; i++)
			send_dir(make_item($urandom, $urandom, $urandom, pairs[i][0], pairs[i][1]));
		drain();
	endtask

	task automatic test_stream(int src_pct, int sink_pct, int count);
		int i;
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		for (i = 0; i < count; i++)
			send_dir(draw_item());
		drain();
	endtask

	// long receiver hold while the sender keeps offering
	task automatic test_backpressure;
		int i;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		sink_hold_left = 120;
		for (i = 0; i < 60; i++)
			send_dir(draw_item());
		drain();
	endtask

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		src_idle_pct = 0;
		sink_stall_pct = 0;
		sink_hold_left = 0;
		items_sent = 0;
		values_checked = 0;
		bad_index_seen = 0;
		saturated_seen = 0;
		mismatches = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_all_indexes();
		test_bad_index();
		test_stream(0, 0, 415);
		test_stream(88, 0, 415);
		test_stream(0, 88, 415);
		test_stream(26, 26, 415);
		test_backpressure();
		repeat (20) @(posedge clk);
		$display("covered %0d transfers in, %0d values checked over all 25 basis indexes",
			items_sent, values_checked);
		$display("%0d invalid indexes, %0d saturated values, %0d mismatches",
			bad_index_seen, saturated_seen, mismatches);
		if (mismatches == 0 && pending_basis.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* real_sh_basis_eval.f */
design/rsh_pkg.sv
design/rsh_mulrnd.sv
design/real_sh_basis_eval.sv
tb/tb_top.sv
